// ===== src/sap_pkg.sv =====
// Shared types, constants and the microcode program of the skyline atlas packer.
package sap_pkg;

    localparam int PC_W = 4;

    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [2:0] {
        C_NEXT,
        C_NO_IN,
        C_WIDE,
        C_MORE,
        C_OUT_BUSY,
        C_ALWAYS
    } t_cond;

    typedef struct packed {
        logic  in_ready;
        logic  clr;
        logic  setup;
        logic  rd;
        logic  calc;
        logic  wr;
        logic  upd;
        logic  emit;
        t_cond cond;
        t_pc   target;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic wide;
        logic more;
        logic out_busy;
    } t_stat;

    localparam t_pc P_IDLE   = 4'd0;
    localparam t_pc P_CLEAR  = 4'd1;
    localparam t_pc P_CHECK  = 4'd2;
    localparam t_pc P_READ   = 4'd3;
    localparam t_pc P_DRAIN  = 4'd4;
    localparam t_pc P_CALC   = 4'd5;
    localparam t_pc P_WRITE  = 4'd6;
    localparam t_pc P_UPDATE = 4'd7;
    localparam t_pc P_EMIT   = 4'd8;
    localparam t_pc P_GO     = 4'd9;

    localparam logic [8:0]  FOOT_EXTRA = 9'd3;
    localparam logic [8:0]  PAD_TOTAL  = 9'd2;
    localparam logic [15:0] SAT16      = 16'hFFFF;
    localparam logic [10:0] WIDTH_RST  = 11'd1024;

    function automatic t_ctrl f_ucode(input t_pc pc);
        t_ctrl w;
        w        = '0;
        w.cond   = C_NEXT;
        w.target = P_IDLE;
        unique case (pc)
            P_IDLE: begin
                w.in_ready = 1'b1;
                w.cond     = C_NO_IN;
                w.target   = P_IDLE;
            end
            P_CLEAR: begin
                w.clr = 1'b1;
            end
            P_CHECK: begin
                w.setup  = 1'b1;
                w.cond   = C_WIDE;
                w.target = P_EMIT;
            end
            P_READ: begin
                w.rd     = 1'b1;
                w.cond   = C_MORE;
                w.target = P_READ;
            end
            P_DRAIN: begin
                w.cond = C_NEXT;
            end
            P_CALC: begin
                w.calc = 1'b1;
            end
            P_WRITE: begin
                w.wr     = 1'b1;
                w.cond   = C_MORE;
                w.target = P_WRITE;
            end
            P_UPDATE: begin
                w.upd = 1'b1;
            end
            P_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = C_OUT_BUSY;
                w.target = P_EMIT;
            end
            P_GO: begin
                w.cond   = C_ALWAYS;
                w.target = P_IDLE;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = P_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== src/sap_useq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module sap_useq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sap_pkg::t_stat i_stat,
    output sap_pkg::t_ctrl o_ctrl
);
    import sap_pkg::*;

    t_pc   r_pc;
    t_pc   n_pc;
    logic  take;
    t_ctrl ctrl;

    assign ctrl   = f_ucode(r_pc);
    assign o_ctrl = ctrl;

    always_comb begin
        unique case (ctrl.cond)
            C_NEXT:     take = 1'b0;
            C_NO_IN:    take = !i_stat.in_valid;
            C_WIDE:     take = i_stat.wide;
            C_MORE:     take = i_stat.more;
            C_OUT_BUSY: take = i_stat.out_busy;
            C_ALWAYS:   take = 1'b1;
            default:    take = 1'b0;
        endcase
        n_pc = take ? ctrl.target : r_pc + t_pc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= P_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== src/sap_dpath.sv =====
// Datapath: column height memory, skyline scan and raise, cursor and used height.
module sap_dpath #(
    parameter int MAX_W = 1024,
    parameter int CW    = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sap_pkg::t_ctrl i_ctrl,
    input  logic           i_accept,
    input  logic           i_cfg_we,
    input  logic [10:0]    i_cfg_data,
    input  logic [7:0]     i_glyph_width,
    input  logic [7:0]     i_glyph_height,
    input  logic           i_start_new,
    output logic           o_wide_now,
    output logic           o_more,
    output logic [CW-1:0]  o_left,
    output logic [15:0]    o_top,
    output logic [CW-1:0]  o_right,
    output logic [15:0]    o_bottom,
    output logic [15:0]    o_used,
    output logic           o_wide
);
    import sap_pkg::*;

    localparam int AW = $clog2(MAX_W);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_W);

    logic [10:0]   r_atlas_width;
    logic [7:0]    r_gw;
    logic [7:0]    r_gh;
    logic          r_fresh;
    logic [CW-1:0] r_cursor;
    logic [CW-1:0] r_fill;
    logic [15:0]   r_used;
    logic [CW-1:0] r_left;
    logic [8:0]    r_x;
    logic [15:0]   r_top;
    logic [15:0]   r_raised;
    logic [15:0]   r_bottom;
    logic          r_wide;
    logic [15:0]   r_rd_data;
    logic          r_rd_vld;
    logic          r_rd_in;
    logic [15:0]   r_mem [MAX_W];

    logic [CW-1:0] aw_ext;
    logic [CW-1:0] eff;
    logic [CW-1:0] foot;
    logic [CW-1:0] addr;
    logic [CW-1:0] end_col;
    logic [CW-1:0] start_end;
    logic [16:0]   sum_raise;
    logic [16:0]   sum_bottom;

    assign aw_ext     = CW'(r_atlas_width);
    assign eff        = (aw_ext > MAX_C) ? MAX_C : aw_ext;
    assign foot       = CW'(r_gw) + CW'(FOOT_EXTRA);
    assign addr       = r_left + CW'(r_x);
    assign end_col    = r_left + foot;
    assign start_end  = r_cursor + foot;
    assign sum_raise  = {1'b0, r_top} + 17'(r_gh) + 17'(FOOT_EXTRA);
    assign sum_bottom = {1'b0, r_top} + 17'(r_gh) + 17'(PAD_TOTAL);
    assign o_wide_now = foot > eff;
    assign o_more     = (CW'(r_x) + CW'(1)) < foot;

    assign o_left   = r_left;
    assign o_top    = r_top;
    assign o_right  = r_left + CW'(r_gw) + CW'(PAD_TOTAL);
    assign o_bottom = r_bottom;
    assign o_used   = r_used;
    assign o_wide   = r_wide;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr) begin
            r_mem[addr[AW-1:0]] <= r_raised;
        end
        if (i_ctrl.rd) begin
            r_rd_data <= r_mem[addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_width <= WIDTH_RST;
            r_cursor      <= '0;
            r_fill        <= '0;
            r_used        <= '0;
            r_rd_vld      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_atlas_width <= i_cfg_data;
            end
            r_rd_vld <= i_ctrl.rd;
            if (i_ctrl.clr && r_fresh) begin
                r_cursor <= '0;
                r_fill   <= '0;
                r_used   <= '0;
            end
            if (i_ctrl.upd) begin
                r_cursor <= (end_col >= eff) ? '0 : end_col;
                if (end_col > r_fill) begin
                    r_fill <= end_col;
                end
                if (r_bottom > r_used) begin
                    r_used <= r_bottom;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_gw    <= i_glyph_width;
            r_gh    <= i_glyph_height;
            r_fresh <= i_start_new;
        end
        if (i_ctrl.rd) begin
            r_rd_in <= addr < r_fill;
        end
        if (i_ctrl.setup) begin
            r_left <= (start_end >= eff) ? '0 : r_cursor;
            r_x    <= '0;
            r_top  <= '0;
            r_wide <= o_wide_now;
        end else if (r_rd_vld && r_rd_in && (r_rd_data > r_top)) begin
            r_top <= r_rd_data;
        end
        if (i_ctrl.rd || i_ctrl.wr) begin
            r_x <= r_x + 9'd1;
        end
        if (i_ctrl.calc) begin
            r_x      <= '0;
            r_raised <= sum_raise[16] ? SAT16 : sum_raise[15:0];
            r_bottom <= sum_bottom[16] ? SAT16 : sum_bottom[15:0];
        end
        if (i_ctrl.emit && r_wide) begin
            r_left   <= '0;
            r_top    <= '0;
            r_bottom <= '0;
        end
    end

    a_rd_in_atlas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.rd |-> addr < eff)
        else $error("Column read lies outside the atlas width.");

    a_upd_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.upd |-> end_col <= eff)
        else $error("Placed footprint runs past the atlas width.");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= MAX_C)
        else $error("Written column mark exceeds the column store.");

endmodule

// ===== src/skyline_atlas_packer.sv =====
// Skyline atlas packer top level: sequencer, datapath and output word register.
//
// Each input word places one glyph and gives one result word. For a glyph that
// fits, the time from acceptance to the result being offered is set by the
// single-port column height memory: one pass reads every column under the
// footprint to find the top, a second pass writes the raised height back. A
// glyph whose footprint is wider than the atlas skips both passes. After the
// result is loaded, the sequencer steps through its go state back to idle
// before it accepts the next word, so no new glyph is taken while one is in
// work. The block takes the next word while a result still waits at the output,
// and holds the following result until the output is free.
// Columns beyond the highest one written since the last fresh atlas read as
// zero, so reset and start_new need no clearing pass over the memory.
module skyline_atlas_packer #(
    parameter int MAX_ATLAS_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_glyph_width,
    input  logic [7:0]  i_glyph_height,
    input  logic        i_start_new,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [9:0]  o_place_left,
    output logic [15:0] o_place_top,
    output logic [10:0] o_place_right,
    output logic [15:0] o_place_bottom,
    output logic [15:0] o_used_height,
    output logic        o_too_wide,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_data
);
    import sap_pkg::*;

    localparam int CW = ($clog2(MAX_ATLAS_WIDTH) + 2 > 12) ? $clog2(MAX_ATLAS_WIDTH) + 2 : 12;

    t_ctrl         ctrl;
    t_stat         stat;
    logic          accept;
    logic          load;
    logic          wide_now;
    logic          more;
    logic [CW-1:0] d_left;
    logic [15:0]   d_top;
    logic [CW-1:0] d_right;
    logic [15:0]   d_bottom;
    logic [15:0]   d_used;
    logic          d_wide;
    logic          r_ov;
    logic [9:0]    r_left;
    logic [15:0]   r_top;
    logic [10:0]   r_right;
    logic [15:0]   r_bottom;
    logic [15:0]   r_used;
    logic          r_wide;

    assign o_ready = ctrl.in_ready;
    assign accept  = i_valid && ctrl.in_ready;

    assign stat.in_valid = i_valid;
    assign stat.wide     = wide_now;
    assign stat.more     = more;
    assign stat.out_busy = r_ov && !i_ready;

    assign load = ctrl.emit && !stat.out_busy;

    sap_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    sap_dpath #(
        .MAX_W (MAX_ATLAS_WIDTH),
        .CW    (CW)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_accept       (accept),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_glyph_width  (i_glyph_width),
        .i_glyph_height (i_glyph_height),
        .i_start_new    (i_start_new),
        .o_wide_now     (wide_now),
        .o_more         (more),
        .o_left         (d_left),
        .o_top          (d_top),
        .o_right        (d_right),
        .o_bottom       (d_bottom),
        .o_used         (d_used),
        .o_wide         (d_wide)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_left   <= d_wide ? '0 : d_left[9:0];
            r_top    <= d_wide ? '0 : d_top;
            r_right  <= d_wide ? '0 : d_right[10:0];
            r_bottom <= d_wide ? '0 : d_bottom;
            r_used   <= d_used;
            r_wide   <= d_wide;
        end
    end

    assign o_valid        = r_ov;
    assign o_place_left   = r_left;
    assign o_place_top    = r_top;
    assign o_place_right  = r_right;
    assign o_place_bottom = r_bottom;
    assign o_used_height  = r_used;
    assign o_too_wide     = r_wide;

endmodule
